[rtl/cat_pkg.sv]
// Package: shared types, status codes and the microcode program of the table core.
`default_nettype none

package cat_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef logic [4:0] upc_t;

    // Wait condition of a step: the step holds until it is satisfied.
    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN,
        WT_OUT
    } wait_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_STATUS,
        EM_FOUND,
        EM_DUMP
    } emit_t;

    typedef enum logic [1:0] {
        IX_HOLD,
        IX_ZERO,
        IX_POS1,
        IX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CN_HOLD,
        CN_INC,
        CN_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_SHIFT
    } wr_t;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_DISPATCH,
        JC_FULL,
        JC_EMPTY,
        JC_BADPOS,
        JC_IDX_END,
        JC_LAST_IDX,
        JC_MATCH
    } jcond_t;

    typedef struct packed {
        wait_t   wt;
        emit_t   em;
        status_t st;
        idx_op_t ix;
        cnt_op_t cn;
        wr_t     wr;
        jcond_t  jc;
        upc_t    tgt;
        upc_t    nxt;
    } ucode_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic    in_valid;
        logic    out_free;
        logic    full;
        logic    empty;
        logic    badpos;
        logic    idx_end;
        logic    last_idx;
        logic    match;
        action_t action;
    } flags_t;

    // Datapath controls driven by the sequencer.
    typedef struct packed {
        logic    go;
        logic    in_ready;
        emit_t   em;
        status_t st;
        idx_op_t ix;
        cnt_op_t cn;
        wr_t     wr;
    } dp_ctrl_t;

    localparam upc_t U_FETCH      = 5'd0;
    localparam upc_t U_INS        = 5'd1;
    localparam upc_t U_INS_WR     = 5'd2;
    localparam upc_t U_REM        = 5'd3;
    localparam upc_t U_REM_CHK    = 5'd4;
    localparam upc_t U_SHIFT      = 5'd5;
    localparam upc_t U_REM_END    = 5'd6;
    localparam upc_t U_DMP        = 5'd7;
    localparam upc_t U_DMP_EM     = 5'd8;
    localparam upc_t U_SRC        = 5'd9;
    localparam upc_t U_SRC_CMP    = 5'd10;
    localparam upc_t U_SRC_INC    = 5'd11;
    localparam upc_t U_R_OK       = 5'd12;
    localparam upc_t U_R_FULL     = 5'd13;
    localparam upc_t U_R_EMPTY    = 5'd14;
    localparam upc_t U_R_BADPOS   = 5'd15;
    localparam upc_t U_R_NOTFOUND = 5'd16;
    localparam upc_t U_R_FOUND    = 5'd17;

    localparam ucode_t UC_NOP = '{
        wt: WT_NONE, em: EM_NONE, st: ST_OK, ix: IX_HOLD, cn: CN_HOLD,
        wr: WR_NONE, jc: JC_ALWAYS, tgt: U_FETCH, nxt: U_FETCH
    };

    // First step of each operation.
    function automatic upc_t dispatch_target(action_t a);
        upc_t t;
        case (a)
            ACT_INSERT: t = U_INS;
            ACT_REMOVE: t = U_REM;
            ACT_DUMP:   t = U_DMP;
            ACT_SEARCH: t = U_SRC;
            default:    t = U_FETCH;
        endcase
        return t;
    endfunction

    // Microcode program.
    function automatic ucode_t ucode_rom(upc_t a);
        ucode_t w;
        w = UC_NOP;
        case (a)
            U_FETCH: begin
                w.wt = WT_IN;
                w.jc = JC_DISPATCH;
            end
            U_INS: begin
                w.jc  = JC_FULL;
                w.tgt = U_R_FULL;
                w.nxt = U_INS_WR;
            end
            U_INS_WR: begin
                w.wr  = WR_APPEND;
                w.cn  = CN_INC;
                w.tgt = U_R_OK;
            end
            U_REM: begin
                w.jc  = JC_EMPTY;
                w.tgt = U_R_EMPTY;
                w.nxt = U_REM_CHK;
            end
            U_REM_CHK: begin
                w.ix  = IX_POS1;
                w.jc  = JC_BADPOS;
                w.tgt = U_R_BADPOS;
                w.nxt = U_SHIFT;
            end
            U_SHIFT: begin
                w.ix  = IX_INC;
                w.wr  = WR_SHIFT;
                w.jc  = JC_IDX_END;
                w.tgt = U_REM_END;
                w.nxt = U_SHIFT;
            end
            U_REM_END: begin
                w.cn  = CN_DEC;
                w.tgt = U_R_OK;
            end
            U_DMP: begin
                w.ix  = IX_ZERO;
                w.jc  = JC_EMPTY;
                w.tgt = U_R_EMPTY;
                w.nxt = U_DMP_EM;
            end
            U_DMP_EM: begin
                w.wt  = WT_OUT;
                w.em  = EM_DUMP;
                w.ix  = IX_INC;
                w.jc  = JC_LAST_IDX;
                w.tgt = U_FETCH;
                w.nxt = U_DMP_EM;
            end
            U_SRC: begin
                w.ix  = IX_ZERO;
                w.jc  = JC_EMPTY;
                w.tgt = U_R_EMPTY;
                w.nxt = U_SRC_CMP;
            end
            U_SRC_CMP: begin
                w.jc  = JC_MATCH;
                w.tgt = U_R_FOUND;
                w.nxt = U_SRC_INC;
            end
            U_SRC_INC: begin
                w.ix  = IX_INC;
                w.jc  = JC_LAST_IDX;
                w.tgt = U_R_NOTFOUND;
                w.nxt = U_SRC_CMP;
            end
            U_R_OK: begin
                w.wt = WT_OUT;
                w.em = EM_STATUS;
                w.st = ST_OK;
            end
            U_R_FULL: begin
                w.wt = WT_OUT;
                w.em = EM_STATUS;
                w.st = ST_FULL;
            end
            U_R_EMPTY: begin
                w.wt = WT_OUT;
                w.em = EM_STATUS;
                w.st = ST_EMPTY;
            end
            U_R_BADPOS: begin
                w.wt = WT_OUT;
                w.em = EM_STATUS;
                w.st = ST_BADPOS;
            end
            U_R_NOTFOUND: begin
                w.wt = WT_OUT;
                w.em = EM_STATUS;
                w.st = ST_NOTFOUND;
            end
            U_R_FOUND: begin
                w.wt = WT_OUT;
                w.em = EM_FOUND;
                w.st = ST_OK;
            end
            default: begin
                w = UC_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/compacting_array_table_core.sv]
// Top level: packed value table with insert, remove, dump and linear search.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: action; s_tdata: value, position
//  m_      | out | m_tvalid/m_tready  | m_tuser: status; m_tdata: found_index,
//          |     |                    |   element, count; m_tlast: last
//
//  The time after the input transaction is set by the microcode steps and the registered
//  RAM read. A new input is taken only in the fetch step, once the steps of the request
//  before it are done. Reset clears the step counter, the index, the entry count and the
//  output valid; the entry RAM is not cleared.
//  A result waits in the output register; hold the emit step while it is not taken.
`default_nettype none

module compacting_array_table_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], position[38:32], pad[39]
    input  wire logic [1:0]  s_tuser,   // action[1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // found_index[5:0], element[37:6],
                                        // count[44:38], pad[47:45]
    output logic      [2:0]  m_tuser,   // status[2:0]
    output logic             m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [6:0] CAP_C = 7'(CAPACITY);

    cat_pkg::flags_t   flags;
    cat_pkg::dp_ctrl_t ctrl;

    // Latched request.
    logic signed [31:0] val_reg;
    logic        [6:0]  pos_reg;

    // Scan index and entry count.
    logic [6:0] idx_reg;
    logic [6:0] idx_next;
    logic [6:0] idx_inc;
    logic [6:0] idx_dec;
    logic [6:0] cnt_reg;
    logic [6:0] cnt_next;

    // Entry RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // Output register.
    logic                 m_valid_reg;
    cat_pkg::status_t     m_status_reg;
    logic [5:0]           m_idx_reg;
    logic signed [31:0]   m_elem_reg;
    logic [6:0]           m_cnt_reg;
    logic                 m_last_reg;

    logic in_take;
    logic out_load;
    logic out_free;

    assign s_tready = ctrl.in_ready;
    assign in_take  = s_tvalid && ctrl.in_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = ctrl.go && (ctrl.em != cat_pkg::EM_NONE);
    assign idx_inc  = idx_reg + 7'd1;
    assign idx_dec  = idx_reg - 7'd1;

    always_comb begin
        flags.in_valid = s_tvalid;
        flags.out_free = out_free;
        flags.full     = (cnt_reg >= CAP_C);
        flags.empty    = (cnt_reg == 7'd0);
        flags.badpos   = (pos_reg >= cnt_reg);
        flags.idx_end  = (idx_reg >= cnt_reg);
        flags.last_idx = (idx_inc >= cnt_reg);
        flags.match    = (ram_rdata == val_reg);
        flags.action   = cat_pkg::action_t'(s_tuser);
    end

    cat_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // Advance the scan index; the RAM reads at the index the next step will see.
    always_comb begin
        idx_next = idx_reg;
        if (ctrl.go) begin
            case (ctrl.ix)
                cat_pkg::IX_HOLD: idx_next = idx_reg;
                cat_pkg::IX_ZERO: idx_next = 7'd0;
                cat_pkg::IX_POS1: idx_next = pos_reg + 7'd1;
                cat_pkg::IX_INC:  idx_next = idx_inc;
                default:          idx_next = idx_reg;
            endcase
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.go) begin
            case (ctrl.cn)
                cat_pkg::CN_HOLD: cnt_next = cnt_reg;
                cat_pkg::CN_INC:  cnt_next = cnt_reg + 7'd1;
                cat_pkg::CN_DEC:  cnt_next = cnt_reg - 7'd1;
                default:          cnt_next = cnt_reg;
            endcase
        end
    end

    // Append writes at the count; a shift moves the entry just read down one place.
    always_comb begin
        ram_we    = ctrl.go && (ctrl.wr != cat_pkg::WR_NONE);
        ram_raddr = idx_next[AW-1:0];
        case (ctrl.wr)
            cat_pkg::WR_APPEND: begin
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = val_reg;
            end
            cat_pkg::WR_SHIFT: begin
                ram_waddr = idx_dec[AW-1:0];
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = val_reg;
            end
        endcase
    end

    cat_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 7'd0;
            cnt_reg <= 7'd0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    // Capture the request on the input transaction.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            val_reg <= s_tdata[31:0];
            pos_reg <= s_tdata[38:32];
        end
    end

    // Result register: load on an emit step, drop valid once the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= ctrl.st;
            m_cnt_reg    <= cnt_reg;
            case (ctrl.em)
                cat_pkg::EM_DUMP: begin
                    m_idx_reg  <= idx_reg[5:0];
                    m_elem_reg <= ram_rdata;
                    m_last_reg <= flags.last_idx;
                end
                cat_pkg::EM_FOUND: begin
                    m_idx_reg  <= idx_reg[5:0];
                    m_elem_reg <= 32'sd0;
                    m_last_reg <= 1'b1;
                end
                default: begin
                    m_idx_reg  <= 6'd0;
                    m_elem_reg <= 32'sd0;
                    m_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_elem_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

    // The entry count never passes the capacity.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP_C)
        else $error("entry count above capacity");

    // No new request is taken while a dump is still streaming results.
    a_no_take_mid_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> !(m_valid_reg && !m_last_reg))
        else $error("input taken while a dump is in progress");

    // A full status always reports a table at capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == cat_pkg::ST_FULL)) |-> (m_cnt_reg == CAP_C))
        else $error("full status with count below capacity");

endmodule

`default_nettype wire

[rtl/cat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/cat_seq.sv]
// Microcode sequencer: step counter, program table lookup and jump logic.
`default_nettype none

module cat_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cat_pkg::flags_t   flags,
    output cat_pkg::dp_ctrl_t      ctrl
);

    cat_pkg::upc_t   upc_reg;
    cat_pkg::upc_t   upc_next;
    cat_pkg::ucode_t word;
    logic            wait_ok;
    logic            taken;

    always_comb begin
        word = cat_pkg::ucode_rom(upc_reg);

        case (word.wt)
            cat_pkg::WT_NONE: wait_ok = 1'b1;
            cat_pkg::WT_IN:   wait_ok = flags.in_valid;
            cat_pkg::WT_OUT:  wait_ok = flags.out_free;
            default:          wait_ok = 1'b1;
        endcase

        case (word.jc)
            cat_pkg::JC_ALWAYS:   taken = 1'b1;
            cat_pkg::JC_FULL:     taken = flags.full;
            cat_pkg::JC_EMPTY:    taken = flags.empty;
            cat_pkg::JC_BADPOS:   taken = flags.badpos;
            cat_pkg::JC_IDX_END:  taken = flags.idx_end;
            cat_pkg::JC_LAST_IDX: taken = flags.last_idx;
            cat_pkg::JC_MATCH:    taken = flags.match;
            default:              taken = 1'b0;
        endcase

        // Hold the step until its wait condition clears.
        if (!wait_ok) begin
            upc_next = upc_reg;
        end else if (word.jc == cat_pkg::JC_DISPATCH) begin
            upc_next = cat_pkg::dispatch_target(flags.action);
        end else if (taken) begin
            upc_next = word.tgt;
        end else begin
            upc_next = word.nxt;
        end

        ctrl.go       = wait_ok;
        ctrl.in_ready = (word.wt == cat_pkg::WT_IN);
        ctrl.em       = word.em;
        ctrl.st       = word.st;
        ctrl.ix       = word.ix;
        ctrl.cn       = word.cn;
        ctrl.wr       = word.wr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= cat_pkg::U_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

[verif/tb_compacting_array_table_core.sv]
// Testbench for compacting_array_table_core: directed and random operations vs a mirror.
module tb_compacting_array_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_CAP   = 64;
    localparam int STALL_LIMIT = 4000;   // cycles without any transaction
    localparam int SETTLE_CYCLES = 40;   // quiet cycles after the last result

    typedef struct packed {
        cat_pkg::status_t status;
        logic [5:0]       found_index;
        logic [31:0]      element;
        logic [6:0]       count;
        logic             last;
    } table_result_t;

    // Mirror of the packed table and of the results each request must produce.
    class table_mirror;
        logic [31:0]   entries [TABLE_CAP];
        int unsigned   fill;
        int unsigned   full_hits;
        int unsigned   mismatches;
        table_result_t awaited[$];

        function new();
            fill       = 0;
            full_hits  = 0;
            mismatches = 0;
        endfunction

        function void queue_result(cat_pkg::status_t st, logic [5:0] idx,
                                   logic [31:0] elem, logic last);
            table_result_t r;
            r.status      = st;
            r.found_index = idx;
            r.element     = elem;
            r.count       = 7'(fill);
            r.last        = last;
            awaited.push_back(r);
        endfunction

        function string describe(table_result_t r);
            return $sformatf("status=%0d index=%0d element=%0d count=%0d last=%0d",
                             r.status, r.found_index, $signed(r.element), r.count, r.last);
        endfunction

        // Apply one accepted request to the mirror and queue its results.
        function void apply_request(cat_pkg::action_t act, logic [31:0] val,
                                    logic [6:0] pos);
            int unsigned i;
            bit          hit;
            case (act)
                cat_pkg::ACT_INSERT: begin
                    if (fill < TABLE_CAP) begin
                        entries[fill] = val;
                        fill++;
                        queue_result(cat_pkg::ST_OK, '0, '0, 1'b1);
                    end else begin
                        full_hits++;
                        queue_result(cat_pkg::ST_FULL, '0, '0, 1'b1);
                    end
                end
                cat_pkg::ACT_REMOVE: begin
                    if (fill == 0) begin
                        queue_result(cat_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else if (pos >= fill) begin
                        queue_result(cat_pkg::ST_BADPOS, '0, '0, 1'b1);
                    end else begin
                        // close the gap: every later entry moves down one place
                        for (i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
                        fill--;
                        queue_result(cat_pkg::ST_OK, '0, '0, 1'b1);
                    end
                end
                cat_pkg::ACT_DUMP: begin
                    if (fill == 0) begin
                        queue_result(cat_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < fill; i++)
                            queue_result(cat_pkg::ST_OK, 6'(i), entries[i], i + 1 == fill);
                    end
                end
                default: begin
                    if (fill == 0) begin
                        queue_result(cat_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        hit = 1'b0;
                        for (i = 0; i < fill && !hit; i++) begin
                            if (entries[i] == val) begin
                                hit = 1'b1;
                                queue_result(cat_pkg::ST_OK, 6'(i), '0, 1'b1);
                            end
                        end
                        if (!hit) queue_result(cat_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                    end
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest outstanding one.
        function void match_result(table_result_t got);
            table_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %s", $time,
                         describe(got));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.found_index !== want.found_index ||
                got.element !== want.element || got.count !== want.count ||
                got.last !== want.last) begin
                mismatches++;
                $display("%0t: result mismatch, expected %s, got %s", $time,
                         describe(want), describe(got));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], position[38:32], pad[39]
    logic [1:0]  s_tuser  = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // found_index[5:0], element[37:6], count[44:38], pad[47:45]
    logic [2:0]  m_tuser;         // status[2:0]
    logic        m_tlast;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    table_mirror mirror;

    compacting_array_table_core #(
        .CAPACITY (TABLE_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Present one request, optionally after an idle gap, and hold it until taken.
    task automatic send_item(input cat_pkg::action_t act, input logic [31:0] val,
                             input logic [6:0] pos);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, pos, val};
        do @(posedge aclk); while (!s_tready);
        mirror.apply_request(act, val, pos);
    endtask

    // Hold the input idle until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (mirror.awaited.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return $urandom();
        if (r < 65) return 32'($urandom_range(7));     // small pool: duplicates
        if (r < 80) return ~32'($urandom_range(3));    // -1 .. -4
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Random requests; insert_pct tilts the table toward growth or shrinkage.
    task automatic run_random_phase(input int unsigned n_items, input int unsigned insert_pct,
                                    input bit fill_up);
        int unsigned      k;
        int unsigned      r;
        cat_pkg::action_t act;
        logic [31:0]      val;
        logic [6:0]       pos;
        k = 0;
        while (k < n_items || (fill_up && mirror.full_hits < 3 && k < 4 * n_items)) begin
            r = $urandom_range(99);
            if (r < insert_pct) begin
                act = cat_pkg::ACT_INSERT;
            end else begin
                r = $urandom_range(99);
                act = (r < 45) ? cat_pkg::ACT_REMOVE :
                      (r < 85) ? cat_pkg::ACT_SEARCH : cat_pkg::ACT_DUMP;
            end
            val = pick_value();
            // mostly search for values that are present
            if (act == cat_pkg::ACT_SEARCH && mirror.fill != 0 && $urandom_range(99) < 60)
                val = mirror.entries[$urandom_range(mirror.fill - 1)];
            r   = $urandom_range(99);
            pos = 7'($urandom_range(127));
            if (mirror.fill != 0 && r < 70) pos = 7'($urandom_range(mirror.fill - 1));
            else if (r < 80) pos = 7'(mirror.fill);
            send_item(act, val, pos);
            k++;
        end
    endtask

    // Result side: check every accepted result, stall at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                mirror.match_result('{status: cat_pkg::status_t'(m_tuser),
                                      found_index: m_tdata[5:0],
                                      element: m_tdata[37:6], count: m_tdata[44:38],
                                      last: m_tlast});
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        mirror = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: dump, search and remove all report empty.
        send_item(cat_pkg::ACT_DUMP,   32'h0000_0000, 7'd0);
        send_item(cat_pkg::ACT_SEARCH, 32'h0000_0000, 7'd0);
        send_item(cat_pkg::ACT_REMOVE, 32'hffff_ffff, 7'd127);
        // Extreme values, with a duplicate to exercise first-match search.
        send_item(cat_pkg::ACT_INSERT, 32'h8000_0000, 7'd0);
        send_item(cat_pkg::ACT_INSERT, 32'h7fff_ffff, 7'd127);
        send_item(cat_pkg::ACT_INSERT, 32'h0000_0000, 7'd0);
        send_item(cat_pkg::ACT_INSERT, 32'hffff_ffff, 7'd0);
        send_item(cat_pkg::ACT_INSERT, 32'h7fff_ffff, 7'd0);
        send_item(cat_pkg::ACT_SEARCH, 32'h7fff_ffff, 7'd0);
        send_item(cat_pkg::ACT_SEARCH, 32'hffff_ffff, 7'd0);
        send_item(cat_pkg::ACT_SEARCH, 32'h8000_0000, 7'd0);
        send_item(cat_pkg::ACT_SEARCH, 32'h1234_5678, 7'd0);   // no match
        // Invalid positions: far out of range and exactly at the count.
        send_item(cat_pkg::ACT_REMOVE, 32'h0000_0000, 7'd127);
        send_item(cat_pkg::ACT_REMOVE, 32'h0000_0000, 7'd5);
        // Remove the last entry, the first entry, then one in the middle.
        send_item(cat_pkg::ACT_REMOVE, 32'h0000_0000, 7'd4);
        send_item(cat_pkg::ACT_REMOVE, 32'h0000_0000, 7'd0);
        send_item(cat_pkg::ACT_DUMP,   32'h0000_0000, 7'd0);
        send_item(cat_pkg::ACT_REMOVE, 32'h0000_0000, 7'd1);
        send_item(cat_pkg::ACT_DUMP,   32'h0000_0000, 7'd0);
        drain_results();

        // Random phases: no idling, sender gaps, receiver stalls, both.
        run_random_phase(50, 75, 1'b0);
        src_idle_pct = 54;
        run_random_phase(50, 90, 1'b1);
        drain_results();
        src_idle_pct   = 0;
        sink_stall_pct = 54;
        run_random_phase(50, 20, 1'b0);
        src_idle_pct   = 12;
        sink_stall_pct = 12;
        run_random_phase(50, 50, 1'b0);

        s_tvalid <= 1'b0;
        while (mirror.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[compacting_array_table_core.f]
rtl/cat_pkg.sv
rtl/cat_ram.sv
rtl/cat_seq.sv
rtl/compacting_array_table_core.sv
verif/tb_compacting_array_table_core.sv
